@@ hdl/pcw_pkg.sv @@
// Shared constants, register codes and table-building helpers for the power curve waveshaper.
package pcw_pkg;

   localparam int DEFAULT_LUT_ADDR_BITS = 10;
   localparam int NUM_STAGES = 8;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_AMOUNT_KNOB = 2'd0,
      REG_CV_SCALE    = 2'd1,
      REG_RANGE_MODE  = 2'd2
   } csr_index_type;

   localparam logic signed [15:0] AMOUNT_KNOB_RESET = 16'sd0;
   localparam logic signed [13:0] CV_SCALE_RESET    = 14'sd4096;
   localparam logic               RANGE_MODE_RESET  = 1'b0;

   localparam logic [15:0] FULL_LOW  = 16'd20480;
   localparam logic [15:0] FULL_HIGH = 16'd40960;

   localparam logic signed [19:0] EXP_LIMIT_POS = 20'sd20480;
   localparam logic signed [19:0] EXP_LIMIT_NEG = -20'sd20480;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [15:0] RECIP_FIVE = 16'd13107;
   localparam logic [17:0] P_ONE      = 18'd65536;

   localparam logic signed [7:0] SHIFT_LIMIT = 8'sd20;

   function automatic logic [15:0] log_frac(input logic [63:0] mant);
      logic [63:0] y;
      logic [15:0] r;
      int          i;
      y = mant;
      r = '0;
      for (i = 0; i < 16; i++) begin
         y = (y * y) >> 30;
         r = {r[14:0], 1'b0};
         if (y >= 64'h0000_0000_8000_0000) begin
            y = y >> 1;
            r[0] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/power_curve_waveshaper_top.sv @@
// Top level of the power curve waveshaper: register file and eight-stage datapath.
//
// Channel  Ports                                   Beat contents
// req      req_valid, req_ready                    req_signal_in, req_amount_cv
// rsp      rsp_valid, rsp_ready                    rsp_signal_out
// csr      csr_psel, csr_penable, csr_pwrite, ...  amount_knob, cv_scale, range_mode
//
// One beat per cycle is sustained while the result is taken, that is while rsp_ready stays high.
// The eight register stages include the log ROM read in stage five and the exp ROM read in stage seven.
// Reset is synchronous and clears the stage valid bits and the configuration registers.
// A stalled result holds the last stage while earlier stages keep filling empty slots.
// The req_ready output drops only when every stage holds a beat and the result is not taken.
module power_curve_waveshaper_top #(
   parameter int LUT_ADDR_BITS = pcw_pkg::DEFAULT_LUT_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [16:0]                 req_signal_in,
   input  logic signed [16:0]                 req_amount_cv,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [16:0]                 rsp_signal_out,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcw_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pcw_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pcw_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import pcw_pkg::*;

   logic signed [15:0] amount_knob_ff;
   logic signed [13:0] cv_scale_ff;
   logic               range_mode_ff;
   csr_index_type      csr_index;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_knob_ff <= AMOUNT_KNOB_RESET;
         cv_scale_ff    <= CV_SCALE_RESET;
         range_mode_ff  <= RANGE_MODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_AMOUNT_KNOB: amount_knob_ff <= csr_pwdata[15:0];
            REG_CV_SCALE:    cv_scale_ff    <= csr_pwdata[13:0];
            REG_RANGE_MODE:  range_mode_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_AMOUNT_KNOB: csr_prdata = {16'd0, amount_knob_ff};
         REG_CV_SCALE:    csr_prdata = {18'd0, cv_scale_ff};
         REG_RANGE_MODE:  csr_prdata = {31'd0, range_mode_ff};
         default:         csr_prdata = '0;
      endcase
   end

   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-1:1], req_valid};
   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 1; i <= NUM_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Stage 1: clamp the sample magnitude and form the CV product.
   logic [16:0]        sig_bits;
   logic [16:0]        x_mag;
   logic [15:0]        full_scale;
   logic signed [30:0] cv_ext;
   logic signed [30:0] scale_ext;
   logic               sign1_in;
   logic [15:0]        m1_in;
   logic signed [30:0] cvp1_in;
   logic               sign1_ff;
   logic [15:0]        m1_ff;
   logic signed [30:0] cvp1_ff;

   assign sig_bits   = req_signal_in;
   assign x_mag      = sig_bits[16] ? (~sig_bits + 17'd1) : sig_bits;
   assign full_scale = range_mode_ff ? FULL_HIGH : FULL_LOW;
   assign sign1_in   = sig_bits[16];
   assign m1_in      = (x_mag > {1'b0, full_scale}) ? full_scale : x_mag[15:0];
   assign cv_ext     = 31'(req_amount_cv);
   assign scale_ext  = 31'(cv_scale_ff);
   assign cvp1_in    = cv_ext * scale_ext;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sign1_ff <= sign1_in;
         m1_ff    <= m1_in;
         cvp1_ff  <= cvp1_in;
      end
   end

   // Stage 2: estimate u by a reciprocal multiply and clamp the exponent sum.
   logic [18:0]        v2_in;
   logic [34:0]        uprod;
   logic [16:0]        uq2_in;
   logic signed [19:0] e_sum;
   logic signed [19:0] e_clamp;
   logic               eneg2_in;
   logic [14:0]        emag2_in;
   logic [18:0]        v2_ff;
   logic [16:0]        uq2_ff;
   logic               eneg2_ff;
   logic [14:0]        emag2_ff;
   logic               sign2_ff;

   assign v2_in  = range_mode_ff ? 19'({m1_ff, 3'b000}) : 19'({m1_ff, 4'b0000});
   assign uprod  = 35'(v2_in) * 35'(RECIP_FIVE);
   assign uq2_in = uprod[32:16];
   assign e_sum  = 20'(amount_knob_ff) + 20'(cvp1_ff >>> 12);

   always_comb begin
      if (e_sum > EXP_LIMIT_POS) begin
         e_clamp = EXP_LIMIT_POS;
      end else if (e_sum < EXP_LIMIT_NEG) begin
         e_clamp = EXP_LIMIT_NEG;
      end else begin
         e_clamp = e_sum;
      end
   end

   assign eneg2_in = e_clamp[19];
   assign emag2_in = eneg2_in ? 15'(-e_clamp) : 15'(e_clamp);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         v2_ff    <= v2_in;
         uq2_ff   <= uq2_in;
         eneg2_ff <= eneg2_in;
         emag2_ff <= emag2_in;
         sign2_ff <= sign1_ff;
      end
   end

   // Stage 3: correct u and estimate the exponent quotient.
   logic [19:0] urem;
   logic [16:0] u3_in;
   logic [18:0] w3_in;
   logic [34:0] nprod;
   logic [16:0] nq3_in;
   logic [16:0] u3_ff;
   logic [18:0] w3_ff;
   logic [16:0] nq3_ff;
   logic        eneg3_ff;
   logic        sign3_ff;

   assign urem   = 20'(v2_ff) - (20'(uq2_ff) << 2) - 20'(uq2_ff);
   assign u3_in  = uq2_ff + ((urem >= 20'd5) ? 17'd1 : 17'd0);
   assign w3_in  = {emag2_ff, 4'b0000};
   assign nprod  = 35'(w3_in) * 35'(RECIP_FIVE);
   assign nq3_in = nprod[32:16];

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         u3_ff    <= u3_in;
         w3_ff    <= w3_in;
         nq3_ff   <= nq3_in;
         eneg3_ff <= eneg2_ff;
         sign3_ff <= sign2_ff;
      end
   end

   // Stage 4: form the power, normalize u and pick the log table entry.
   logic [19:0]              nrem;
   logic [16:0]              nmag;
   logic [17:0]              p4_in;
   logic [3:0]               k4_in;
   logic [16:0]              y4;
   logic [LUT_ADDR_BITS-1:0] lidx4_in;
   logic [LUT_ADDR_BITS-1:0] lidx4_ff;
   logic [3:0]               k4_ff;
   logic [17:0]              p4_ff;
   logic                     zero4_ff;
   logic                     full4_ff;
   logic                     sign4_ff;

   assign nrem  = 20'(w3_ff) - (20'(nq3_ff) << 2) - 20'(nq3_ff);
   assign nmag  = nq3_ff + ((nrem >= 20'd5) ? 17'd1 : 17'd0);
   assign p4_in = eneg3_ff ? (P_ONE - 18'(nmag >> 1)) : (P_ONE + 18'(nmag));

   always_comb begin
      k4_in = '0;
      for (int b = 0; b < 16; b++) begin
         if (u3_ff[b]) begin
            k4_in = 4'(b);
         end
      end
   end

   assign y4       = 17'(u3_ff[15:0]) << (5'd16 - 5'(k4_in));
   assign lidx4_in = y4[15 -: LUT_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         lidx4_ff <= lidx4_in;
         k4_ff    <= k4_in;
         p4_ff    <= p4_in;
         zero4_ff <= (u3_ff == 17'd0);
         full4_ff <= u3_ff[16];
         sign4_ff <= sign3_ff;
      end
   end

   // Stage 5: log table read.
   logic [15:0]              log_data;
   logic [16:0]              exp_data;
   logic [LUT_ADDR_BITS-1:0] eidx;
   logic [3:0]               k5_ff;
   logic [17:0]              p5_ff;
   logic                     zero5_ff;
   logic                     full5_ff;
   logic                     sign5_ff;

   pcw_tables #(
      .LUT_ADDR_BITS(LUT_ADDR_BITS)
   ) u_tables (
      .clock    (clock),
      .log_en   (adv[5]),
      .log_addr (lidx4_ff),
      .log_data (log_data),
      .exp_en   (adv[7]),
      .exp_addr (eidx),
      .exp_data (exp_data)
   );

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         k5_ff    <= k4_ff;
         p5_ff    <= p4_ff;
         zero5_ff <= zero4_ff;
         full5_ff <= full4_ff;
         sign5_ff <= sign4_ff;
      end
   end

   // Stage 6: scale the log by the power.
   logic signed [20:0] lval;
   logic signed [18:0] pval;
   logic signed [39:0] zprod;
   logic signed [22:0] z6_in;
   logic signed [22:0] z6_ff;
   logic               zero6_ff;
   logic               full6_ff;
   logic               sign6_ff;

   assign lval  = {1'b1, k5_ff, log_data};
   assign pval  = {1'b0, p5_ff};
   assign zprod = 40'(lval) * 40'(pval);
   assign z6_in = zprod[38:16];

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         z6_ff    <= z6_in;
         zero6_ff <= zero5_ff;
         full6_ff <= full5_ff;
         sign6_ff <= sign5_ff;
      end
   end

   // Stage 7: exp table read and shift decode.
   logic signed [7:0] ipart;
   logic signed [7:0] shift_amt;
   logic              kill7;
   logic [4:0]        s7_ff;
   logic              zero7_ff;
   logic              full7_ff;
   logic              sign7_ff;

   assign eidx      = z6_ff[15 -: LUT_ADDR_BITS];
   assign ipart     = 8'($signed(z6_ff[22:16]));
   assign shift_amt = -ipart;
   assign kill7     = (shift_amt < 8'sd0) || (shift_amt >= SHIFT_LIMIT);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_ff    <= shift_amt[4:0];
         zero7_ff <= zero6_ff || kill7;
         full7_ff <= full6_ff;
         sign7_ff <= sign6_ff;
      end
   end

   // Stage 8: rescale to the output range and restore the sign.
   logic [16:0]        rval;
   logic [18:0]        rfive;
   logic [15:0]        out_mag;
   logic signed [16:0] out8_in;
   logic signed [16:0] out8_ff;

   always_comb begin
      if (full7_ff) begin
         rval = ONE_Q16;
      end else if (zero7_ff) begin
         rval = '0;
      end else begin
         rval = exp_data >> s7_ff;
      end
   end

   assign rfive   = (19'(rval) << 2) + 19'(rval);
   assign out_mag = range_mode_ff ? 16'(rfive >> 3) : 16'(rfive >> 4);
   assign out8_in = sign7_ff ? -$signed({1'b0, out_mag}) : $signed({1'b0, out_mag});

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         out8_ff <= out8_in;
      end
   end

   assign rsp_signal_out = out8_ff;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input stalled while the result stage was empty.");

   a_u_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (u3_ff <= ONE_Q16))
      else $error("Normalized magnitude exceeds one.");

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (p4_ff >= 18'd32768 && p4_ff <= 18'd131072))
      else $error("Exponent outside the range one half to two.");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !adv[4] |=> valid_ff[4] && $stable(p4_ff))
      else $error("Stalled beat in the power stage was lost or changed.");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !range_mode_ff |->
         (rsp_signal_out <= 17'sd20480 && rsp_signal_out >= -17'sd20480))
      else $error("Result exceeds the five volt range.");

endmodule

@@ hdl/pcw_tables.sv @@
// Log2 and exp2 lookup ROMs with registered read ports for the waveshaper pipeline.
module pcw_tables #(
   parameter int LUT_ADDR_BITS = pcw_pkg::DEFAULT_LUT_ADDR_BITS
) (
   input  logic                     clock,
   input  logic                     log_en,
   input  logic [LUT_ADDR_BITS-1:0] log_addr,
   output logic [15:0]              log_data,
   input  logic                     exp_en,
   input  logic [LUT_ADDR_BITS-1:0] exp_addr,
   output logic [16:0]              exp_data
);
   import pcw_pkg::*;

   localparam int LUT_DEPTH = 1 << LUT_ADDR_BITS;

   typedef logic [15:0] log_rom_type [LUT_DEPTH];
   typedef logic [16:0] exp_rom_type [LUT_DEPTH];

   function automatic log_rom_type build_log_rom();
      log_rom_type rom;
      int          i;
      for (i = 0; i < LUT_DEPTH; i++) begin
         rom[i] = log_frac((64'd1 << 30) + (64'(i) << (30 - LUT_ADDR_BITS)));
      end
      return rom;
   endfunction

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      int          i;
      logic [16:0] lo;
      logic [16:0] hi;
      logic [16:0] mid;
      logic [15:0] target;
      for (i = 0; i < LUT_DEPTH; i++) begin
         target = 16'(i << (16 - LUT_ADDR_BITS));
         lo = 17'd65536;
         hi = 17'd131071;
         while (lo < hi) begin
            mid = lo + ((hi - lo + 17'd1) >> 1);
            if (log_frac(64'(mid) << 14) <= target) begin
               lo = mid;
            end else begin
               hi = mid - 17'd1;
            end
         end
         rom[i] = lo;
      end
      return rom;
   endfunction

   localparam log_rom_type LOG_ROM = build_log_rom();
   localparam exp_rom_type EXP_ROM = build_exp_rom();

   logic [15:0] log_data_ff;
   logic [16:0] exp_data_ff;

   always_ff @(posedge clock) begin
      if (log_en) begin
         log_data_ff <= LOG_ROM[log_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (exp_en) begin
         exp_data_ff <= EXP_ROM[exp_addr];
      end
   end

   assign log_data = log_data_ff;
   assign exp_data = exp_data_ff;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the power curve waveshaper: directed, random and backpressure tests.
`timescale 1ns / 1ps

module testbench;
   import pcw_pkg::*;

   localparam int CLOCK_PERIOD_NS = 10;
   localparam int RESET_CYCLES = 7;
   localparam int PIPE_LATENCY = NUM_STAGES;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int TIMEOUT_NS = 2_000_000;
   localparam int ADDR_BITS = DEFAULT_LUT_ADDR_BITS;
   localparam int TABLE_SIZE = 1 << ADDR_BITS;
   localparam longint UNITY = 65536;
   localparam int unsigned UNUSED_INDEX = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [16:0] req_signal_in = '0;
   logic signed [16:0] req_amount_cv = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [16:0] rsp_signal_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   logic signed [15:0] knob_setting = AMOUNT_KNOB_RESET;
   logic signed [13:0] scale_setting = CV_SCALE_RESET;
   logic wide_range = RANGE_MODE_RESET;
   logic [15:0] log_table [TABLE_SIZE];
   logic [16:0] exp_table [TABLE_SIZE];

   logic signed [16:0] pending_shaped [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_left = 0;

   power_curve_waveshaper_top #(.LUT_ADDR_BITS(ADDR_BITS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_signal_in(req_signal_in),
      .req_amount_cv(req_amount_cv),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_signal_out(rsp_signal_out),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(CLOCK_PERIOD_NS / 2) clock = ~clock;

   // Fractional bits of log2 of a Q30 mantissa in [1,2), by repeated squaring.
   function automatic logic [15:0] log2_fraction(input logic [63:0] mant_q30);
      logic [63:0] acc;
      logic [15:0] bits_out;
      acc = mant_q30;
      bits_out = '0;
      for (int i = 0; i < 16; i++) begin
         acc = (acc * acc) >> 30;
         bits_out = bits_out << 1;
         if (acc >= 64'h8000_0000) begin
            acc = acc >> 1;
            bits_out[0] = 1'b1;
         end
      end
      return bits_out;
   endfunction

   function automatic void build_tables();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      logic [31:0] target;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         log_table[i] = log2_fraction((64'd1 << 30) + (64'(i) << (30 - ADDR_BITS)));
         target = 32'(i) << (16 - ADDR_BITS);
         lo = 32'd65536;
         hi = 32'd131071;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (32'(log2_fraction(64'(mid) << 14)) <= target)
               lo = mid;
            else
               hi = mid - 1;
         end
         exp_table[i] = lo[16:0];
      end
   endfunction

   function automatic logic signed [16:0] shape_sample(input logic signed [16:0] sample,
                                                       input logic signed [16:0] cv);
      longint full, mag, u, e, n, p, y, l, z, whole, frac, shift, r;
      int k;
      full = wide_range ? longint'(FULL_HIGH) : longint'(FULL_LOW);
      mag = longint'(sample);
      if (mag < 0)
         mag = -mag;
      if (mag > full)
         mag = full;
      u = mag * UNITY / full;

      e = longint'(knob_setting) + ((longint'(cv) * longint'(scale_setting)) >>> 12);
      if (e > 20480)
         e = 20480;
      if (e < -20480)
         e = -20480;
      n = e * 16 / 5;
      p = (n >= 0) ? UNITY + n : UNITY + n / 2;

      if (u <= 0) begin
         r = 0;
      end else if (u >= UNITY) begin
         r = UNITY;
      end else begin
         k = 15;
         while (k > 0 && !u[k])
            k--;
         y = u << (16 - k);
         l = longint'(k - 16) * UNITY
             + longint'(log_table[int'(((y - UNITY) >> (16 - ADDR_BITS)) & (TABLE_SIZE - 1))]);
         z = (l * p) >>> 16;
         whole = z >>> 16;
         frac = z - whole * UNITY;
         shift = -whole;
         if (shift >= 20 || shift < 0)
            r = 0;
         else
            r = longint'(exp_table[int'((frac >> (16 - ADDR_BITS)) & (TABLE_SIZE - 1))]) >> shift;
      end

      r = (r * full) >>> 16;
      if (sample < 0)
         r = -r;
      return r[16:0];
   endfunction

   function automatic int random_voltage();
      int boundary [8] = '{0, 1, 4096, 20480, 20481, 40960, 40961, 65535};
      int pick;
      int value;
      pick = $urandom_range(9);
      if (pick < 5) begin
         value = int'($urandom_range(98304)) - 49152;
      end else if (pick < 8) begin
         value = int'($urandom_range(131071)) - 65536;
      end else begin
         value = boundary[$urandom_range(7)];
         if ($urandom_range(1))
            value = -value;
      end
      return value;
   endfunction

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      logic signed [16:0] predicted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_shaped.size() == 0) begin
            $error("signal_out beat with no prediction: actual %0d", rsp_signal_out);
            error_count++;
         end else begin
            predicted = pending_shaped.pop_front();
            if (rsp_signal_out !== predicted) begin
               $error("signal_out mismatch: expected %0d, actual %0d", predicted, rsp_signal_out);
               error_count++;
            end
         end
      end
   end

   task automatic write_register(input int unsigned index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(index * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_AMOUNT_KNOB: knob_setting = value[15:0];
         REG_CV_SCALE: scale_setting = value[13:0];
         REG_RANGE_MODE: wide_range = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input int knob, input int scale, input int mode);
      write_register(32'(REG_AMOUNT_KNOB), 32'(knob));
      write_register(32'(REG_CV_SCALE), 32'(scale));
      write_register(32'(REG_RANGE_MODE), 32'(mode));
   endtask

   task automatic send_sample(input int sample, input int cv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_signal_in <= 17'(sample);
      req_amount_cv <= 17'(cv);
      do @(posedge clock); while (!req_ready);
      pending_shaped.push_back(shape_sample(17'(sample), 17'(cv)));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_shaped.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_sample(0, 0);
      send_sample(20480, 0);
      send_sample(-20480, 0);
      send_sample(65535, 0);
      send_sample(-65536, 0);
      send_sample(1, 0);
      send_sample(-1, 65535);
      send_sample(10240, -65536);
      send_sample(-10240, 20480);
      send_sample(20479, -20480);
      wait_drained();
   endtask

   task automatic test_range_and_exponent_limits();
      apply_settings(-20480, -4096, 1);
      send_sample(40960, 0);
      send_sample(-40960, 0);
      send_sample(40961, 0);
      send_sample(20480, 49152);
      send_sample(-12345, -49152);
      send_sample(1, 0);
      wait_drained();
      apply_settings(32767, 8191, 0);
      send_sample(5000, 0);
      send_sample(-5000, -65536);
      wait_drained();
   endtask

   task automatic test_unknown_register();
      write_register(UNUSED_INDEX, 32'hFFFF_FFFF);
      send_sample(7000, 1234);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count)
         send_sample(random_voltage(), random_voltage());
      wait_drained();
   endtask

   task automatic test_output_backpressure(input int count);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (count)
         send_sample(random_voltage(), random_voltage());
      wait_drained();
   endtask

   task automatic test_sender_pause(input int count);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      repeat (count / 2)
         send_sample(random_voltage(), random_voltage());
      wait_drained();
      repeat (count - count / 2)
         send_sample(random_voltage(), random_voltage());
      wait_drained();
   endtask

   initial begin
      build_tables();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_range_and_exponent_limits();
      test_unknown_register();

      apply_settings(-32768, -8192, 1);
      test_random_traffic(90, 0, 0);
      apply_settings(int'($urandom_range(49152)) - 24576, int'($urandom_range(16383)) - 8192,
                     $urandom_range(1));
      test_random_traffic(90, 64, 0);
      apply_settings(20480, 4096, 0);
      test_random_traffic(90, 0, 64);
      apply_settings(int'($urandom_range(49152)) - 24576, int'($urandom_range(16383)) - 8192,
                     $urandom_range(1));
      test_random_traffic(90, 16, 16);
      apply_settings(0, 4096, 1);
      test_output_backpressure(50);
      apply_settings(int'($urandom_range(49152)) - 24576, int'($urandom_range(16383)) - 8192,
                     $urandom_range(1));
      test_sender_pause(40);

      repeat (2 * PIPE_LATENCY) @(negedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
hdl/pcw_pkg.sv
hdl/pcw_tables.sv
hdl/power_curve_waveshaper_top.sv
dv/testbench.sv
